### hdl/ctcgd_pkg.sv
package ctcgd_pkg;

  localparam int MaxClassesDef = 128;
  localparam int ScoreWidth    = 16;
  localparam int CfgWidth      = 8;
  localparam int ResetClasses  = 69;
  localparam int TableSize     = 69;
  localparam int IndexWidth    = 7;
  localparam int CharWidth     = 7;
  localparam int QueueDepth    = 2;

  typedef struct packed {
    logic signed [ScoreWidth-1:0] score;
    logic                         last_in_sequence;
  } in_req_t;

  typedef struct packed {
    logic [IndexWidth-1:0] symbol_index;
    logic [CharWidth-1:0]  symbol_char;
    logic                  symbol_valid;
    logic                  end_of_sequence;
  } out_req_t;

  // One finished time step, as handed from the front to the back.
  typedef struct packed {
    logic [IndexWidth-1:0] index;
    logic                  in_table;
    logic                  fresh;
    logic                  eos;
  } step_t;

  function automatic logic [CharWidth-1:0] lookup_char(logic [IndexWidth-1:0] idx);
    logic [CharWidth-1:0] ch;
    ch = '0;
    priority if (idx == 7'd0) begin
      ch = 7'd45;
    end else if (idx <= 7'd26) begin
      ch = idx + 7'd96;
    end else if (idx <= 7'd36) begin
      ch = idx + 7'd21;
    end else if (idx <= 7'd62) begin
      ch = idx + 7'd28;
    end else if (idx == 7'd63) begin
      ch = 7'd44;
    end else if (idx == 7'd64) begin
      ch = 7'd46;
    end else if (idx == 7'd65) begin
      ch = 7'd63;
    end else if (idx == 7'd66) begin
      ch = 7'd33;
    end else if (idx == 7'd67) begin
      ch = 7'd32;
    end else begin
      ch = '0;
    end
    return ch;
  endfunction

endpackage

### hdl/ctcgd_front.sv
module ctcgd_front import ctcgd_pkg::*; #(
  parameter int MAX_CLASSES = MaxClassesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  input  logic                accept_i,
  input  in_req_t             req_i,
  output logic                step_valid_o,
  output step_t               step_o
);

  localparam int PosW = $clog2(MAX_CLASSES);
  localparam int CntW = PosW + 1;

  logic [CfgWidth-1:0]  num_classes_q;
  logic signed [ScoreWidth-1:0] best_score_q, best_score_d;
  logic [PosW-1:0]      best_idx_q, best_idx_d;
  logic [PosW-1:0]      pos_q, pos_d;
  logic [PosW-1:0]      prev_q, prev_d;
  logic                 have_prev_q, have_prev_d;

  logic [CntW-1:0]      eff_count;
  logic                 better;
  logic                 step_end;
  logic [PosW-1:0]      win;
  logic                 fresh;

  always_comb begin
    priority if (num_classes_q == '0) begin
      eff_count = CntW'(1);
    end else if ({1'b0, num_classes_q} > (CfgWidth+1)'(MAX_CLASSES)) begin
      eff_count = CntW'(MAX_CLASSES);
    end else begin
      eff_count = CntW'(num_classes_q);
    end
  end

  assign better   = req_i.score > best_score_q;
  assign win      = better ? pos_q : best_idx_q;
  // The step also ends if the count was lowered below the current position.
  assign step_end = (CntW'(pos_q) + CntW'(1)) >= eff_count;
  assign fresh    = !have_prev_q || (win != prev_q);

  assign step_valid_o    = accept_i && step_end && (fresh || req_i.last_in_sequence);
  assign step_o.index    = IndexWidth'(win);
  assign step_o.in_table = (PosW + 8)'(win) < (PosW + 8)'(TableSize);
  assign step_o.fresh    = fresh;
  assign step_o.eos      = req_i.last_in_sequence;

  always_comb begin
    best_score_d = best_score_q;
    best_idx_d   = best_idx_q;
    pos_d        = pos_q;
    prev_d       = prev_q;
    have_prev_d  = have_prev_q;
    if (accept_i) begin
      if (step_end) begin
        best_score_d = '0;
        best_idx_d   = '0;
        pos_d        = '0;
        if (req_i.last_in_sequence) begin
          prev_d      = '0;
          have_prev_d = 1'b0;
        end else begin
          prev_d      = win;
          have_prev_d = 1'b1;
        end
      end else begin
        pos_d = pos_q + PosW'(1);
        if (better) begin
          best_score_d = req_i.score;
          best_idx_d   = pos_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_classes_q <= CfgWidth'(ResetClasses);
      best_score_q  <= '0;
      best_idx_q    <= '0;
      pos_q         <= '0;
      prev_q        <= '0;
      have_prev_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        num_classes_q <= cfg_wdata_i;
      end
      best_score_q <= best_score_d;
      best_idx_q   <= best_idx_d;
      pos_q        <= pos_d;
      prev_q       <= prev_d;
      have_prev_q  <= have_prev_d;
    end
  end

endmodule

### hdl/ctcgd_queue.sv
module ctcgd_queue import ctcgd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_en_i,
  input  step_t wr_data_i,
  output logic  full_o,
  input  logic  rd_en_i,
  output logic  not_empty_o,
  output step_t rd_data_o
);

  localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int CntW = $clog2(QueueDepth + 1);

  step_t           mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_wr, do_rd;

  assign full_o      = count_q == CntW'(QueueDepth);
  assign not_empty_o = count_q != '0;
  assign rd_data_o   = mem_q[rd_ptr_q];
  assign do_wr       = wr_en_i && !full_o;
  assign do_rd       = rd_en_i && not_empty_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

### hdl/ctcgd_back.sv
module ctcgd_back import ctcgd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     head_valid_i,
  input  step_t    head_i,
  output logic     head_take_o,
  output logic     empty_o,
  input  logic     pop_i,
  output out_req_t res_o
);

  logic     out_valid_q;
  out_req_t out_q, out_d;

  // The output register refills in the same cycle that its request is taken.
  assign head_take_o = head_valid_i && (!out_valid_q || pop_i);
  assign empty_o     = !out_valid_q;
  assign res_o       = out_q;

  always_comb begin
    out_d.symbol_index    = head_i.index;
    out_d.symbol_char     = head_i.in_table ? lookup_char(head_i.index) : '0;
    out_d.symbol_valid    = head_i.fresh;
    out_d.end_of_sequence = head_i.eos;
  end

  always_ff @(posedge clk_i) begin
    if (head_take_o) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (head_take_o) begin
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

### hdl/ctc_greedy_decoder.sv
// Throughput: one score per cycle, sustained, while results are popped as they appear.
// Each time step's request passes through the step queue and then the output register on
// its way to the result ports; the output register loads only when it is empty or popped.
// The input side stalls only when the two-entry step queue is full.
// Reset clears all control state and sets the class count to 69; output payload
// registers and step queue storage are not reset.
module ctc_greedy_decoder import ctcgd_pkg::*; #(
  parameter int MAX_CLASSES = MaxClassesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  input  logic                push,
  output logic                full,
  input  in_req_t             req_i,
  output logic                empty,
  input  logic                pop,
  output out_req_t            res_o
);

  logic  accept;
  logic  step_valid;
  step_t step;
  logic  q_full;
  logic  q_not_empty;
  step_t q_head;
  logic  q_take;

  assign full   = q_full;
  assign accept = push && !q_full;

  ctcgd_front #(
    .MAX_CLASSES(MAX_CLASSES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .req_i       (req_i),
    .step_valid_o(step_valid),
    .step_o      (step)
  );

  ctcgd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (step_valid),
    .wr_data_i  (step),
    .full_o     (q_full),
    .rd_en_i    (q_take),
    .not_empty_o(q_not_empty),
    .rd_data_o  (q_head)
  );

  ctcgd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(q_not_empty),
    .head_i      (q_head),
    .head_take_o (q_take),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res_o)
  );

endmodule

### tb/ctc_greedy_decoder_tb.sv
module ctc_greedy_decoder_tb;
  import ctcgd_pkg::*;

  typedef enum logic [1:0] {ROW_CFG, ROW_SCORE} row_kind_e;
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_RESULT} check_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [15:0] data;
    logic        last;
    check_e      check;
    out_req_t    typed;
  } row_t;

  localparam logic [CharWidth-1:0] CharDash = 7'd45;
  localparam logic [CharWidth-1:0] CharLowA = 7'd97;
  localparam logic [CharWidth-1:0] CharLowB = 7'd98;
  localparam int HoldCycles = 64;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgWidth-1:0] cfg_wdata_i = '0;
  logic                push = 1'b0;
  logic                full;
  in_req_t             score_req = '0;
  logic                empty;
  logic                pop = 1'b0;
  out_req_t            symbol_res;

  // Predictor state.
  logic [CfgWidth-1:0]          class_count;
  logic signed [ScoreWidth-1:0] best_score;
  int                           best_index;
  int                           class_pos;
  int                           prev_index;
  bit                           have_prev;

  out_req_t pending_symbols[$];
  row_t     rows[$];
  int       err_count = 0;
  bit       idling_on = 1'b1;
  bit       hold_request = 1'b0;
  string    symbol_set =
    "-abcdefghijklmnopqrstuvwxyz0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ,.?! ";

  ctc_greedy_decoder i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .req_i       (score_req),
    .empty       (empty),
    .pop         (pop),
    .res_o       (symbol_res)
  );

  always #4 clk_i = ~clk_i;

  function automatic int eff_classes();
    if (class_count == 0) return 1;
    if (class_count > MaxClassesDef) return MaxClassesDef;
    return class_count;
  endfunction

  function automatic logic [CharWidth-1:0] char_of(int idx);
    byte c;
    if (idx >= symbol_set.len()) return '0;
    c = symbol_set[idx];
    return c[CharWidth-1:0];
  endfunction

  task automatic decode_score(input in_req_t r, output bit produced, output out_req_t res);
    int win;
    bit fresh;
    produced = 1'b0;
    res = '0;
    if (r.score > best_score) begin
      best_score = r.score;
      best_index = class_pos;
    end
    // A step ends on the first score that reaches the count, even one lowered mid-step.
    if (class_pos + 1 < eff_classes()) begin
      class_pos++;
      return;
    end
    win = best_index;
    fresh = !have_prev || win != prev_index;
    if (fresh || r.last_in_sequence) begin
      produced = 1'b1;
      res.symbol_index = win[IndexWidth-1:0];
      res.symbol_char = char_of(win);
      res.symbol_valid = fresh;
      res.end_of_sequence = r.last_in_sequence;
    end
    best_score = '0;
    best_index = 0;
    class_pos = 0;
    have_prev = !r.last_in_sequence;
    prev_index = r.last_in_sequence ? 0 : win;
  endtask

  task automatic send_score(input logic [15:0] score, input logic last, input bit predict);
    in_req_t r;
    bit produced;
    out_req_t res;
    r.score = score;
    r.last_in_sequence = last;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    push <= 1'b1;
    score_req <= r;
    do @(posedge clk_i); while (full);
    decode_score(r, produced, res);
    if (predict && produced) pending_symbols.push_back(res);
  endtask

  // Waits until every expected request has come and the pipeline has settled.
  task automatic drain();
    push <= 1'b0;
    while (pending_symbols.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_classes(input logic [CfgWidth-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    class_count = value;
  endtask

  task automatic run_phase(input logic [CfgWidth-1:0] classes, input int budget,
                           input bit idle, input bit hold);
    int sent;
    int eff;
    int steps;
    int target;
    int prev_target;
    int peak;
    int mode;
    int tmp;
    int s;
    logic last;
    drain();
    write_classes(classes);
    idling_on = idle;
    if (hold) hold_request = 1'b1;
    eff = eff_classes();
    sent = 0;
    prev_target = 0;
    while (sent < budget) begin
      steps = $urandom_range(1, 5);
      for (int st = 0; st < steps && sent < budget; st++) begin
        // Repeated winners exercise the duplicate suppression.
        case ($urandom_range(0, 9))
          0, 1, 2, 3: target = (prev_target < eff) ? prev_target : 0;
          4, 5:       target = eff - 1;
          default:    target = $urandom_range(0, eff - 1);
        endcase
        prev_target = target;
        mode = $urandom_range(0, 4);
        peak = $urandom_range(1, 32767);
        for (int p = 0; p < eff; p++) begin
          case (mode)
            0, 1: begin
              if (p == target) begin
                s = peak;
              end else begin
                tmp = $urandom_range(0, peak + 32767);
                s = tmp - 32768;
              end
            end
            2: s = -int'($urandom_range(0, 32768));
            3: s = $urandom;
            default: s = int'($urandom_range(0, 3)) - 1;
          endcase
          if (p == eff - 1) last = (st == steps - 1);
          else last = ($urandom_range(0, 9) == 0);
          send_score(s[15:0], last, 1'b1);
          sent++;
        end
      end
    end
    // Leave a step unfinished now and then, so that the next count applies mid-step.
    if ($urandom_range(0, 1) == 1) begin
      tmp = $urandom_range(0, eff - 1);
      for (int p = 0; p < tmp; p++) begin
        s = $urandom;
        send_score(s[15:0], 1'(($urandom_range(0, 3) == 0)), 1'b1);
      end
    end
  endtask

  initial begin : result_sink
    int burst_left;
    int hold_left;
    out_req_t want;
    burst_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (pop && !empty) begin
        if (pending_symbols.size() == 0) begin
          $error("Unexpected request: symbol_index %0d", symbol_res.symbol_index);
          err_count++;
        end else begin
          want = pending_symbols.pop_front();
          if (symbol_res.symbol_index !== want.symbol_index) begin
            $error("symbol_index: expected %0d, got %0d",
                   want.symbol_index, symbol_res.symbol_index);
            err_count++;
          end
          if (symbol_res.symbol_char !== want.symbol_char) begin
            $error("symbol_char: expected %0d, got %0d",
                   want.symbol_char, symbol_res.symbol_char);
            err_count++;
          end
          if (symbol_res.symbol_valid !== want.symbol_valid) begin
            $error("symbol_valid: expected %0d, got %0d",
                   want.symbol_valid, symbol_res.symbol_valid);
            err_count++;
          end
          if (symbol_res.end_of_sequence !== want.end_of_sequence) begin
            $error("end_of_sequence: expected %0d, got %0d",
                   want.end_of_sequence, symbol_res.end_of_sequence);
            err_count++;
          end
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (burst_left > 0) begin
        burst_left--;
        pop <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        burst_left = $urandom_range(0, 4);
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    #3200000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    class_count = ResetClasses;
    best_score = '0;
    best_index = 0;
    class_pos = 0;
    prev_index = 0;
    have_prev = 1'b0;

    // One class per step: every step wins class 0, so repeats decide the outcome.
    rows.push_back('{ROW_CFG, 16'd1, 1'b0, CHK_NONE, '0});
    rows.push_back('{ROW_SCORE, 16'h7FFF, 1'b0, CHK_RESULT,
                     out_req_t'{7'd0, CharDash, 1'b1, 1'b0}});
    rows.push_back('{ROW_SCORE, 16'h8000, 1'b0, CHK_NONE, '0});
    rows.push_back('{ROW_SCORE, 16'h0000, 1'b1, CHK_RESULT,
                     out_req_t'{7'd0, CharDash, 1'b0, 1'b1}});
    rows.push_back('{ROW_SCORE, 16'h0001, 1'b1, CHK_RESULT,
                     out_req_t'{7'd0, CharDash, 1'b1, 1'b1}});
    // A count of zero behaves as one.
    rows.push_back('{ROW_CFG, 16'd0, 1'b0, CHK_NONE, '0});
    rows.push_back('{ROW_SCORE, 16'h0100, 1'b0, CHK_RESULT,
                     out_req_t'{7'd0, CharDash, 1'b1, 1'b0}});
    rows.push_back('{ROW_SCORE, 16'hFFFF, 1'b1, CHK_RESULT,
                     out_req_t'{7'd0, CharDash, 1'b0, 1'b1}});
    // Three classes: a tie keeps the earlier class.
    rows.push_back('{ROW_CFG, 16'd3, 1'b0, CHK_NONE, '0});
    rows.push_back('{ROW_SCORE, 16'd1, 1'b0, CHK_NONE, '0});
    rows.push_back('{ROW_SCORE, 16'd2, 1'b0, CHK_NONE, '0});
    rows.push_back('{ROW_SCORE, 16'd2, 1'b1, CHK_RESULT,
                     out_req_t'{7'd1, CharLowA, 1'b1, 1'b1}});
    rows.push_back('{ROW_SCORE, 16'hFFFB, 1'b0, CHK_NONE, '0});
    rows.push_back('{ROW_SCORE, 16'hFFFB, 1'b0, CHK_NONE, '0});
    rows.push_back('{ROW_SCORE, 16'hFFFB, 1'b0, CHK_RESULT,
                     out_req_t'{7'd0, CharDash, 1'b1, 1'b0}});
    // The end flag on a score inside a step does not end the sequence.
    rows.push_back('{ROW_SCORE, 16'd0, 1'b1, CHK_NONE, '0});
    rows.push_back('{ROW_SCORE, 16'd0, 1'b0, CHK_NONE, '0});
    rows.push_back('{ROW_SCORE, 16'd7, 1'b1, CHK_RESULT,
                     out_req_t'{7'd2, CharLowB, 1'b1, 1'b1}});
    rows.push_back('{ROW_CFG, 16'd2, 1'b0, CHK_NONE, '0});
    rows.push_back('{ROW_SCORE, 16'h8000, 1'b0, CHK_MODEL, '0});
    rows.push_back('{ROW_SCORE, 16'h7FFF, 1'b0, CHK_MODEL, '0});
    rows.push_back('{ROW_SCORE, 16'h7FFF, 1'b0, CHK_MODEL, '0});
    rows.push_back('{ROW_SCORE, 16'h0001, 1'b1, CHK_MODEL, '0});
    rows.push_back('{ROW_SCORE, 16'h0000, 1'b1, CHK_MODEL, '0});

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        drain();
        write_classes(rows[i].data[CfgWidth-1:0]);
      end else begin
        send_score(rows[i].data, rows[i].last, rows[i].check == CHK_MODEL);
        if (rows[i].check == CHK_RESULT) pending_symbols.push_back(rows[i].typed);
      end
    end

    // The first phase holds the result side off long enough to fill the block.
    run_phase(8'd2, 80, 1'b1, 1'b1);
    run_phase(8'd1, 20, 1'b1, 1'b0);
    run_phase(8'd5, 40, 1'b1, 1'b0);
    run_phase(8'd255, 128, 1'b1, 1'b0);
    run_phase(8'd69, 69, 1'b0, 1'b0);
    run_phase(8'd70, 70, 1'b1, 1'b0);
    run_phase(8'd0, 10, 1'b1, 1'b0);
    run_phase(8'd128, 128, 1'b1, 1'b0);
    run_phase(8'd3, 45, 1'b1, 1'b1);
    run_phase(8'd127, 127, 1'b1, 1'b0);
    run_phase(8'd4, 40, 1'b0, 1'b0);
    drain();
    repeat (8) @(posedge clk_i);

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/ctcgd_pkg.sv
hdl/ctcgd_front.sv
hdl/ctcgd_queue.sv
hdl/ctcgd_back.sv
hdl/ctc_greedy_decoder.sv
tb/ctc_greedy_decoder_tb.sv
